// ===== rtl/grs_pkg.sv =====
// Shared types and constants for the group reversing stream block.
package grs_pkg;

    localparam int MAX_GROUP  = 64;
    localparam int DATA_WIDTH = 16;
    localparam int GS_W       = 7;
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int IDX_W      = $clog2(MAX_GROUP);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  end_of_list;
    } in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value_out;
        logic                  list_done;
        logic                  burst_end;
    } out_t;

    // One closed group handed from the front to the back.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             reverse;
        logic             eol;
    } desc_t;

    // Group buffer write from the front.
    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] data;
    } wr_t;

    // Bank handed back to the front once its last read has issued.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

// ===== rtl/grs_front.sv =====
// Front end: accepts values, fills the ping-pong banks and closes groups.
module grs_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  grs_pkg::in_t            item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [grs_pkg::GS_W-1:0] cfg_data,
    output grs_pkg::wr_t            wr,
    output logic                    desc_push,
    output grs_pkg::desc_t          desc,
    input  logic                    desc_full,
    input  grs_pkg::rel_t           rel
);
    import grs_pkg::*;

    logic [GS_W-1:0]  group_size_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0] k_eff;
    logic [CNT_W-1:0] n_held;
    logic             accept;
    logic             group_full;
    logic             close;

    assign cfg_ready = 1'b1;

    // Zero acts as one and anything above the buffer depth saturates.
    always_comb
    begin
        if (group_size_reg == '0)
            k_eff = CNT_W'(1);
        else if (group_size_reg > GS_W'(MAX_GROUP))
            k_eff = CNT_W'(MAX_GROUP);
        else
            k_eff = CNT_W'(group_size_reg);
    end

    assign full       = busy_reg[bank_reg] || desc_full;
    assign accept     = push && !full;
    assign n_held     = fill_reg + CNT_W'(1);
    assign group_full = (n_held >= k_eff);
    assign close      = accept && (group_full || item.end_of_list);

    assign wr.en   = accept;
    assign wr.addr = {bank_reg, fill_reg[IDX_W-1:0]};
    assign wr.data = item.value;

    assign desc_push    = close;
    assign desc.bank    = bank_reg;
    assign desc.count   = n_held;
    assign desc.reverse = group_full;
    assign desc.eol     = item.end_of_list;

    always_comb
    begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (rel.valid)
            busy_next[rel.bank] = 1'b0;
        if (close)
        begin
            fill_next           = '0;
            bank_next           = !bank_reg;
            busy_next[bank_reg] = 1'b1;
        end
        else if (accept)
        begin
            fill_next = n_held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GS_RESET;
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                group_size_reg <= cfg_data;
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/grs_desc_q.sv =====
// Two-entry queue of closed group descriptors between front and back.
module grs_desc_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  grs_pkg::desc_t din,
    output logic           full,
    input  logic           pop,
    output grs_pkg::desc_t dout,
    output logic           empty
);
    import grs_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/grs_back.sv =====
// Back end: holds the group buffer and drains closed groups into the result queue.
module grs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  grs_pkg::wr_t   wr,
    input  grs_pkg::desc_t desc,
    input  logic           desc_empty,
    output logic           desc_pop,
    output grs_pkg::rel_t  rel,
    output logic           empty,
    input  logic           pop,
    output grs_pkg::out_t  result
);
    import grs_pkg::*;

    logic [DATA_WIDTH-1:0] mem [2 * MAX_GROUP];

    logic                  active_reg;
    desc_t                 cur_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      cnt_m1;
    logic                  last;
    logic                  issue;
    logic [IDX_W-1:0]      rd_idx;

    logic                  rd_valid_reg;
    logic                  rd_done_reg;
    logic                  rd_last_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    out_t                  oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   oq_wr_reg;
    logic [OQ_PTR_W-1:0]   oq_rd_reg;
    logic [OQ_CNT_W-1:0]   oq_cnt_reg, oq_cnt_next;
    logic [OQ_CNT_W-1:0]   oq_pending;
    logic                  oq_pop;
    out_t                  oq_din;

    assign desc_pop = !active_reg && !desc_empty;
    assign cnt_m1   = cur_reg.count - CNT_W'(1);
    assign last     = (CNT_W'(idx_reg) == cnt_m1);
    assign rd_idx   = cur_reg.reverse ? (cnt_m1[IDX_W-1:0] - idx_reg) : idx_reg;

    // Reads in flight count against queue space so no result is ever dropped.
    assign oq_pending = oq_cnt_reg + OQ_CNT_W'(rd_valid_reg);
    assign issue      = active_reg && (oq_pending <= OQ_CNT_W'(OQ_DEPTH - 2));

    assign rel.valid = issue && last;
    assign rel.bank  = cur_reg.bank;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (issue)
            rd_data_reg <= mem[{cur_reg.bank, rd_idx}];
        if (desc_pop)
            cur_reg <= desc;
        if (issue)
        begin
            rd_done_reg <= cur_reg.eol && last;
            rd_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (desc_pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (issue)
            begin
                if (last)
                    active_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    assign oq_din.value_out = rd_data_reg;
    assign oq_din.list_done = rd_done_reg;
    assign oq_din.burst_end = rd_last_reg;

    assign empty  = (oq_cnt_reg == '0);
    assign oq_pop = pop && !empty;
    assign result = oq_reg[oq_rd_reg];

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (rd_valid_reg && !oq_pop)
            oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(1);
        else if (oq_pop && !rd_valid_reg)
            oq_cnt_next = oq_cnt_reg - OQ_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
            oq_reg[oq_wr_reg] <= oq_din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (rd_valid_reg)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

// ===== rtl/group_reverse_stream.sv =====
// Throughput: values enter one per cycle while a free bank exists and the descriptor queue has
// room; a closed group drains through the single read port of the group buffer, overlapped with
// filling the other bank. Reset clears the fill count, bank state and queues and sets group_size
// to 2; the group buffer itself needs no clearing.
module group_reverse_stream (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  grs_pkg::in_t             item,
    output logic                     empty,
    input  logic                     pop,
    output grs_pkg::out_t            result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [grs_pkg::GS_W-1:0] cfg_data
);
    import grs_pkg::*;

    wr_t   wr;
    desc_t desc_in;
    desc_t desc_out;
    rel_t  rel;
    logic  desc_push;
    logic  desc_full;
    logic  desc_pop;
    logic  desc_empty;

    grs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .desc_push (desc_push),
        .desc      (desc_in),
        .desc_full (desc_full),
        .rel       (rel)
    );

    grs_desc_q u_desc_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .din   (desc_in),
        .full  (desc_full),
        .pop   (desc_pop),
        .dout  (desc_out),
        .empty (desc_empty)
    );

    grs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .desc       (desc_out),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .rel        (rel),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the group reversing stream block.
`timescale 1ns / 100ps

module testbench;

    import grs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    in_t               item;
    logic              empty;
    logic              pop;
    out_t              result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GS_W-1:0]   cfg_data;

    // Predictor state: the configured size, the held values and how many are held.
    logic [GS_W-1:0]       size_reg;
    logic [DATA_WIDTH-1:0] held_values [MAX_GROUP];
    int                    held_count;
    out_t                  awaited_values [$];

    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  size_writes;
    int  full_stalls;
    int  cycle_count;
    int  hold_cycles;
    int  pop_wait;
    bit  calm;

    group_reverse_stream uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still awaited",
                     cycle_count, awaited_values.size());
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic int effective_size(input logic [GS_W-1:0] size);
        int k;
        k = int'(size);
        if (k == 0)
            k = 1;
        if (k > MAX_GROUP)
            k = MAX_GROUP;
        return k;
    endfunction

    // Stores one value and queues the beats that it releases, if any.
    task automatic predict_reorder(input logic [DATA_WIDTH-1:0] v, input logic eol);
        int   k;
        int   n;
        out_t beat;
        k = effective_size(size_reg);
        if (held_count >= MAX_GROUP)
            held_count = MAX_GROUP - 1;
        held_values[held_count] = v;
        held_count++;
        n = held_count;
        if (n >= k || eol)
        begin
            for (int i = 0; i < n; i++)
            begin
                beat.value_out = (n >= k) ? held_values[n - 1 - i] : held_values[i];
                beat.burst_end = (i == n - 1);
                beat.list_done = eol && (i == n - 1);
                awaited_values.push_back(beat);
            end
            held_count = 0;
        end
    endtask

    task automatic send_value(input logic [DATA_WIDTH-1:0] v, input logic eol);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            @(negedge clk);
            push = 1'b0;
        end
        @(negedge clk);
        push = 1'b1;
        item.value = v;
        item.end_of_list = eol;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        predict_reorder(v, eol);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        push = 1'b0;
        while (awaited_values.size() != 0)
            @(posedge clk);
    endtask

    // The block may still be closing out work that produces no beat, so let it settle first.
    task automatic write_group_size(input logic [GS_W-1:0] size);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_reg = size;
        size_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_list(input int len);
        for (int j = 0; j < len; j++)
            send_value(16'($urandom_range(0, 65535)),
                       (j == len - 1) || ($urandom_range(0, 15) == 0));
    endtask

    // Receiver: a long hold-off when asked for, otherwise a random wait before each beat.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop = 1'b0;
                hold_cycles--;
            end
            else if (pop_wait > 0)
            begin
                pop = 1'b0;
                pop_wait--;
            end
            else
                pop = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            pop_wait = calm ? 0 : $urandom_range(0, 5);
            results_checked++;
            if (awaited_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value_out=%h list_done=%b burst_end=%b",
                             result.value_out, result.list_done, result.burst_end);
            end
            else
            begin
                out_t want;
                want = awaited_values.pop_front();
                if (result.value_out !== want.value_out
                    || result.list_done !== want.list_done
                    || result.burst_end !== want.burst_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected %h/%b/%b, got %h/%b/%b",
                                 results_checked, want.value_out, want.list_done,
                                 want.burst_end, result.value_out, result.list_done,
                                 result.burst_end);
                end
            end
        end
    end

    // Reset size of two with an odd-length list, so the last value comes out alone.
    task automatic test_reset_size();
        send_value(16'h0000, 1'b0);
        send_value(16'hFFFF, 1'b0);
        send_value(16'h1234, 1'b0);
        send_value(16'h8000, 1'b0);
        send_value(16'h7FFF, 1'b1);
        wait_for_results();
    endtask

    // Sizes of zero and one both pass values straight through.
    task automatic test_pass_through();
        write_group_size(7'd0);
        send_value(16'hAAAA, 1'b0);
        send_value(16'h5555, 1'b1);
        write_group_size(7'd1);
        send_value(16'h0001, 1'b0);
        send_value(16'hFFFE, 1'b1);
        wait_for_results();
    endtask

    // A group closed by the final element, and a list of one element under a larger size.
    task automatic test_list_edges();
        write_group_size(7'd3);
        send_value(16'h0F0F, 1'b0);
        send_value(16'hF0F0, 1'b0);
        send_value(16'h3C3C, 1'b1);
        write_group_size(7'd4);
        send_value(16'hC3C3, 1'b1);
        wait_for_results();
    endtask

    // Lowering the size while values are held releases all of them as one reversed group.
    task automatic test_size_lowered_mid_group();
        write_group_size(7'd8);
        for (int j = 0; j < 5; j++)
            send_value(16'(16'h1000 + j), 1'b0);
        write_group_size(7'd3);
        send_value(16'h2000, 1'b0);
        send_value(16'h2001, 1'b1);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        write_group_size(7'd4);
        calm = 1'b1;
        hold_cycles = 160;
        for (int j = 0; j < 40; j++)
            send_value(16'($urandom_range(0, 65535)), (j % 10) == 9);
        calm = 1'b0;
        // Pause in the middle of a list until everything released so far has drained.
        for (int j = 0; j < 6; j++)
            send_value(16'($urandom_range(0, 65535)), 1'b0);
        wait_for_results();
        send_value(16'($urandom_range(0, 65535)), 1'b0);
        send_value(16'($urandom_range(0, 65535)), 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_lists();
        logic [GS_W-1:0] sizes [10];
        int              k;
        int              sent;
        int              len;
        sizes = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd3, 7'd5, 7'd6,
                  7'($urandom_range(2, 16)), 7'd0, 7'($urandom_range(1, 63))};
        foreach (sizes[p])
        begin
            write_group_size(sizes[p]);
            calm = ($urandom_range(0, 3) == 0);
            k = effective_size(sizes[p]);
            if (k >= 32)
                send_list($urandom_range(k - 3, k + 6));
            else
            begin
                sent = 0;
                while (sent < 10)
                begin
                    len = $urandom_range(1, 2 * k + 2);
                    send_list(len);
                    sent += len;
                end
            end
            wait_for_results();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        size_reg = GS_RESET;
        held_count = 0;
        mismatches = 0;
        items_sent = 0;
        results_checked = 0;
        size_writes = 0;
        full_stalls = 0;
        cycle_count = 0;
        hold_cycles = 0;
        pop_wait = 0;
        calm = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_size();
        test_pass_through();
        test_list_edges();
        test_size_lowered_mid_group();
        test_backpressure();
        test_random_lists();

        wait_for_results();
        repeat (20) @(posedge clk);
        $display("%0d values in, %0d beats checked over %0d group size writes",
                 items_sent, results_checked, size_writes);
        $display("sizes 0 through 127, a long receiver hold-off (%0d cycles with full high)",
                 full_stalls);
        if (mismatches == 0 && awaited_values.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
